// ===== sv/acds_pkg.sv =====
// Shared types, constants and digit helpers for the alarm clock with display scan.
`timescale 1ns / 1ps

package acds_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned InDataWidth   = 8;
  localparam int unsigned OutDataWidth  = 32;

  localparam logic [7:0] DpBit = 8'b1000_0000;
  localparam logic [4:0] NoonHour = 5'd12;

  // Anode-style patterns for digits 0..9; the cathode pattern is their inverse.
  localparam logic [7:0] ANODE_PAT [10] = '{
    8'b1100_0000, 8'b1111_1001, 8'b1010_0100, 8'b1011_0000, 8'b1001_1001,
    8'b1001_0010, 8'b1000_0010, 8'b1111_1000, 8'b1000_0000, 8'b1001_0000
  };

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_ALARM_HOUR        = 3'd0,
    REG_ALARM_MINUTE      = 3'd1,
    REG_TICKS_PER_ADVANCE = 3'd2,
    REG_SETTLE_TICKS      = 3'd3,
    REG_RING_PERIODS      = 3'd4
  } reg_index_e;

  typedef enum logic [1:0] {
    SCAN_MIN_UNITS = 2'd0,
    SCAN_MIN_TENS  = 2'd1,
    SCAN_HR_UNITS  = 2'd2,
    SCAN_HR_TENS   = 2'd3
  } scan_e;

  typedef struct packed {
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic [15:0] ticks_per_advance;
    logic [7:0]  settle_ticks;
    logic [7:0]  ring_periods;
  } cfg_t;

  typedef struct packed {
    logic       prev;
    logic       stable;
    logic [7:0] count;
    logic       fmt;
  } deb_state_t;

  typedef struct packed {
    logic [3:0] mu;
    logic [2:0] mt;
    logic [3:0] hu;
    logic [1:0] ht;
  } bcd_time_t;

  typedef struct packed {
    logic [15:0] prescale;
    bcd_time_t   clk_time;
    logic        ringing;
    logic [7:0]  ring_count;
  } tk_state_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] units;
  } min_split_t;

  typedef struct packed {
    logic [1:0] tens;
    logic [3:0] units;
  } hr_split_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] pat;
    pat = 8'h00;
    if (digit <= 4'd9) begin
      pat = ~ANODE_PAT[digit];
    end
    return pat;
  endfunction

  function automatic min_split_t split_minute(input logic [5:0] m);
    min_split_t r;
    if (m >= 6'd60) begin
      r.tens = 3'd6;
    end else if (m >= 6'd50) begin
      r.tens = 3'd5;
    end else if (m >= 6'd40) begin
      r.tens = 3'd4;
    end else if (m >= 6'd30) begin
      r.tens = 3'd3;
    end else if (m >= 6'd20) begin
      r.tens = 3'd2;
    end else if (m >= 6'd10) begin
      r.tens = 3'd1;
    end else begin
      r.tens = 3'd0;
    end
    r.units = 4'(m - 6'(r.tens) * 6'd10);
    return r;
  endfunction

  function automatic hr_split_t split_hour(input logic [4:0] h);
    hr_split_t r;
    if (h >= 5'd30) begin
      r.tens = 2'd3;
    end else if (h >= 5'd20) begin
      r.tens = 2'd2;
    end else if (h >= 5'd10) begin
      r.tens = 2'd1;
    end else begin
      r.tens = 2'd0;
    end
    r.units = 4'(h - 5'(r.tens) * 5'd10);
    return r;
  endfunction

endpackage

// ===== sv/acds_debounce.sv =====
// Button debouncer and 12/24-hour format toggle, next-state logic.
`timescale 1ns / 1ps

module acds_debounce import acds_pkg::*; (
  input  logic       sample_i,
  input  logic [7:0] settle_ticks_i,
  input  deb_state_t cur_i,
  output deb_state_t nxt_o
);

  always_comb begin
    nxt_o = cur_i;
    if (sample_i != cur_i.prev) begin
      nxt_o.prev  = sample_i;
      nxt_o.count = 8'd0;
    end else if (cur_i.count < settle_ticks_i) begin
      nxt_o.count = cur_i.count + 8'd1;
    end
    // Only a settled rising edge flips the display format.
    if (nxt_o.count == settle_ticks_i && sample_i != cur_i.stable) begin
      nxt_o.stable = sample_i;
      if (sample_i) begin
        nxt_o.fmt = ~cur_i.fmt;
      end
    end
  end

endmodule

// ===== sv/acds_display.sv =====
// Digit multiplexer and seven-segment decode for the current scan position.
`timescale 1ns / 1ps

module acds_display import acds_pkg::*; (
  input  scan_e      scan_i,
  input  bcd_time_t  time_i,
  input  logic       twelve_i,
  output logic [3:0] digit_enable_o,
  output logic [7:0] segments_o,
  output logic       am_o
);

  logic [4:0] h24;
  logic [4:0] h12;
  logic [3:0] disp_t;
  logic [3:0] disp_u;

  assign h24  = 5'(time_i.ht) * 5'd10 + 5'(time_i.hu);
  assign am_o = (h24 < NoonHour);

  always_comb begin
    h12 = (h24 >= NoonHour) ? h24 - NoonHour : h24;
    if (h12 == 5'd0) begin
      h12 = NoonHour;
    end
    if (!twelve_i) begin
      disp_t = 4'(time_i.ht);
      disp_u = time_i.hu;
    end else if (h12 >= 5'd10) begin
      disp_t = 4'd1;
      disp_u = 4'(h12 - 5'd10);
    end else begin
      disp_t = 4'd0;
      disp_u = 4'(h12);
    end
  end

  always_comb begin
    digit_enable_o = 4'b0001 << scan_i;
    unique case (scan_i)
      SCAN_MIN_UNITS: segments_o = seg_of(time_i.mu);
      SCAN_MIN_TENS:  segments_o = seg_of(4'(time_i.mt));
      SCAN_HR_UNITS:  segments_o = seg_of(disp_u) | DpBit;
      SCAN_HR_TENS:   segments_o = (twelve_i && disp_t == 4'd0) ? 8'h00 : seg_of(disp_t);
      default:        segments_o = 8'h00;
    endcase
  end

endmodule

// ===== sv/acds_timekeep.sv =====
// Prescaler, BCD time advance and alarm ringing, next-state logic.
`timescale 1ns / 1ps

module acds_timekeep import acds_pkg::*; (
  input  cfg_t      cfg_i,
  input  tk_state_t cur_i,
  output tk_state_t nxt_o
);

  logic [16:0] pre_inc;
  logic        period;
  logic [8:0]  ring_next;
  logic        match;
  min_split_t  al_min;
  hr_split_t   al_hr;
  bcd_time_t   t;

  assign pre_inc   = {1'b0, cur_i.prescale} + 17'd1;
  assign period    = (pre_inc >= {1'b0, cfg_i.ticks_per_advance});
  assign al_min    = split_minute(cfg_i.alarm_minute);
  assign al_hr     = split_hour(cfg_i.alarm_hour);

  always_comb begin
    t = cur_i.clk_time;
    if (period) begin
      if (t.mu >= 4'd9) begin
        t.mu = 4'd0;
        if (t.mt >= 3'd5) begin
          t.mt = 3'd0;
          if (t.ht == 2'd2) begin
            if (t.hu >= 4'd3) begin
              t.hu = 4'd0;
              t.ht = 2'd0;
            end else begin
              t.hu = t.hu + 4'd1;
            end
          end else if (t.hu >= 4'd9) begin
            t.hu = 4'd0;
            t.ht = t.ht + 2'd1;
          end else begin
            t.hu = t.hu + 4'd1;
          end
        end else begin
          t.mt = t.mt + 3'd1;
        end
      end else begin
        t.mu = t.mu + 4'd1;
      end
    end
  end

  assign match = (t.mu == al_min.units) && (3'(t.mt) == al_min.tens) &&
                 (t.hu == al_hr.units) && (t.ht == al_hr.tens);

  always_comb begin
    nxt_o            = cur_i;
    nxt_o.clk_time   = t;
    nxt_o.prescale   = period ? 16'd0 : pre_inc[15:0];
    // The compare comes before the switch-off, so a start and a stop can meet.
    if (!cur_i.ringing && match) begin
      nxt_o.ringing    = 1'b1;
      nxt_o.ring_count = 8'd0;
    end
    ring_next = {1'b0, nxt_o.ring_count} + 9'd1;
    if (nxt_o.ringing && period) begin
      nxt_o.ring_count = ring_next[7:0];
      if (ring_next >= {1'b0, cfg_i.ring_periods}) begin
        nxt_o.ringing = 1'b0;
      end
    end
  end

endmodule

// ===== sv/alarm_clock_with_display_scan.sv =====
// Top level of the alarm clock: input register, tick logic, result register and settings.
`timescale 1ns / 1ps
// An accepted item waits in the input register; it is processed into the result register
// when that register is empty or being taken, and the result is then valid at the output.
// Throughput: one item per cycle; the input register advances whenever the result register
// is empty or being taken.
// Reset (asynchronous, active low) clears all clock state and loads the setting defaults.

module alarm_clock_with_display_scan import acds_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // Fields from bit 0: button_level, then zero fill.
  input  logic [InDataWidth-1:0]   s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // Fields from bit 0: digit_enable[3:0], segments[11:4], am_indicator[12],
  // alarm_indicator[13], twelve_hour_mode[14], clock_hours[19:15],
  // clock_minutes[25:20], then zero fill.
  output logic [OutDataWidth-1:0]  m_axis_tdata,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  cfg_t       cfg_q;
  logic       in_valid_q;
  logic       in_button_q;
  logic       out_valid_q;
  logic [OutDataWidth-1:0] out_data_q, out_data_d;
  scan_e      scan_q, scan_d;
  deb_state_t deb_q, deb_d;
  tk_state_t  tk_q, tk_d;
  logic       advance;

  logic [3:0] digit_enable;
  logic [7:0] segments;
  logic       am;
  logic [4:0] hours;
  logic [5:0] minutes;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  acds_debounce u_debounce (
    .sample_i       (in_button_q),
    .settle_ticks_i (cfg_q.settle_ticks),
    .cur_i          (deb_q),
    .nxt_o          (deb_d)
  );

  acds_display u_display (
    .scan_i         (scan_q),
    .time_i         (tk_q.clk_time),
    .twelve_i       (deb_d.fmt),
    .digit_enable_o (digit_enable),
    .segments_o     (segments),
    .am_o           (am)
  );

  acds_timekeep u_timekeep (
    .cfg_i (cfg_q),
    .cur_i (tk_q),
    .nxt_o (tk_d)
  );

  assign scan_d  = scan_e'(scan_q + 2'd1);
  assign hours   = 5'(tk_d.clk_time.ht) * 5'd10 + 5'(tk_d.clk_time.hu);
  assign minutes = 6'(tk_d.clk_time.mt) * 6'd10 + 6'(tk_d.clk_time.mu);
  assign out_data_d = {6'd0, minutes, hours, deb_d.fmt, tk_d.ringing, am, segments,
                       digit_enable};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarm_hour        <= 5'd3;
      cfg_q.alarm_minute      <= 6'd5;
      cfg_q.ticks_per_advance <= 16'd200;
      cfg_q.settle_ticks      <= 8'd5;
      cfg_q.ring_periods      <= 8'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ALARM_HOUR:        cfg_q.alarm_hour        <= cfg_data_i[4:0];
        REG_ALARM_MINUTE:      cfg_q.alarm_minute      <= cfg_data_i[5:0];
        REG_TICKS_PER_ADVANCE: cfg_q.ticks_per_advance <= cfg_data_i;
        REG_SETTLE_TICKS:      cfg_q.settle_ticks      <= cfg_data_i[7:0];
        REG_RING_PERIODS:      cfg_q.ring_periods      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      scan_q      <= SCAN_MIN_UNITS;
      deb_q       <= '0;
      tk_q        <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        scan_q      <= scan_d;
        deb_q       <= deb_d;
        tk_q        <= tk_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_button_q <= s_axis_tdata[0];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the alarm clock with display scan: tick predictor and scoreboard.
`timescale 1ns / 1ps

module tb_top import acds_pkg::*; ();

  localparam int CycleLimit = 200000;
  localparam int PrintLimit = 40;

  // Common-cathode patterns for digits 0..9, a..g in bits 0..6.
  localparam logic [7:0] CATHODE_SEG [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  typedef enum {SET_RANDOM, SET_ALL_MAX, SET_ALL_MIN} settings_mode_e;

  typedef struct packed {
    logic [5:0] clock_minutes;
    logic [4:0] clock_hours;
    logic       twelve_hour_mode;
    logic       alarm_indicator;
    logic       am_indicator;
    logic [7:0] segments;
    logic [3:0] digit_enable;
  } tick_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [InDataWidth-1:0]   s_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OutDataWidth-1:0]  m_axis_tdata;
  logic                     cfg_we_i;
  logic [CfgIndexWidth-1:0] cfg_index_i;
  logic [CfgDataWidth-1:0]  cfg_data_i;

  // Predicted clock state and settings.
  scan_e       scan_pos;
  logic [15:0] prescale;
  logic [3:0]  min_u;
  logic [2:0]  min_t;
  logic [3:0]  hr_u;
  logic [1:0]  hr_t;
  logic        btn_prev;
  logic        btn_held;
  logic [7:0]  held_cnt;
  logic        fmt12;
  logic        ringing;
  logic [7:0]  ring_cnt;
  logic [4:0]  set_alarm_hr;
  logic [5:0]  set_alarm_min;
  logic [15:0] set_tpa;
  logic [7:0]  set_deb;
  logic [7:0]  set_ring;

  tick_result_t display_q[$];
  tick_result_t got_result;
  tick_result_t want_result;

  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_left;
  int cycle_count = 0;

  alarm_clock_with_display_scan dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] digit_segments(input logic [3:0] d);
    return (d <= 4'd9) ? CATHODE_SEG[d] : 8'h00;
  endfunction

  function automatic int minutes_now();
    return (hr_t * 10 + hr_u) * 60 + min_t * 10 + min_u;
  endfunction

  task automatic reset_predictor();
    scan_pos = SCAN_MIN_UNITS;
    prescale = '0;
    min_u = '0;
    min_t = '0;
    hr_u = '0;
    hr_t = '0;
    btn_prev = 1'b0;
    btn_held = 1'b0;
    held_cnt = '0;
    fmt12 = 1'b0;
    ringing = 1'b0;
    ring_cnt = '0;
    set_alarm_hr = 5'd3;
    set_alarm_min = 6'd5;
    set_tpa = 16'd200;
    set_deb = 8'd5;
    set_ring = 8'd30;
  endtask

  // One tick in loop order: debounce, scan, prescaler, alarm.
  function automatic tick_result_t predict_tick(input logic lvl);
    tick_result_t r;
    int hour24;
    int hour12;
    int ring_next;
    logic [3:0] shown_t;
    logic [3:0] shown_u;
    logic advanced;
    advanced = 1'b0;
    if (lvl != btn_prev) begin
      btn_prev = lvl;
      held_cnt = '0;
    end else if (held_cnt < set_deb) begin
      held_cnt = held_cnt + 8'd1;
    end
    if (held_cnt == set_deb && lvl != btn_held) begin
      btn_held = lvl;
      if (lvl) begin
        fmt12 = ~fmt12;
      end
    end

    hour24 = hr_t * 10 + hr_u;
    if (fmt12) begin
      hour12 = hour24 % 12;
      if (hour12 == 0) begin
        hour12 = 12;
      end
      shown_t = 4'(hour12 / 10);
      shown_u = 4'(hour12 % 10);
    end else begin
      shown_t = {2'b00, hr_t};
      shown_u = hr_u;
    end
    r.am_indicator = (hour24 < 12);
    r.digit_enable = 4'b0001 << scan_pos;
    case (scan_pos)
      SCAN_MIN_UNITS: r.segments = digit_segments(min_u);
      SCAN_MIN_TENS:  r.segments = digit_segments({1'b0, min_t});
      SCAN_HR_UNITS:  r.segments = digit_segments(shown_u) | DpBit;
      default: begin
        r.segments = (fmt12 && shown_t == 4'd0) ? 8'h00 : digit_segments(shown_t);
      end
    endcase
    scan_pos = scan_e'(2'(scan_pos + 2'd1));

    if (prescale + 32'd1 >= set_tpa) begin
      prescale = '0;
      advanced = 1'b1;
      min_u = min_u + 4'd1;
      if (min_u > 4'd9) begin
        min_u = '0;
        min_t = min_t + 3'd1;
        if (min_t > 3'd5) begin
          min_t = '0;
          if (hr_t == 2'd2) begin
            if (hr_u >= 4'd3) begin
              hr_u = '0;
              hr_t = '0;
            end else begin
              hr_u = hr_u + 4'd1;
            end
          end else if (hr_u >= 4'd9) begin
            hr_u = '0;
            hr_t = hr_t + 2'd1;
          end else begin
            hr_u = hr_u + 4'd1;
          end
        end
      end
    end else begin
      prescale = prescale + 16'd1;
    end

    // The compare comes first, so an alarm that stops inside its minute starts again.
    if (!ringing && min_u == set_alarm_min % 10 && min_t == set_alarm_min / 10 &&
        hr_u == set_alarm_hr % 10 && hr_t == set_alarm_hr / 10) begin
      ringing = 1'b1;
      ring_cnt = '0;
    end
    if (ringing && advanced) begin
      ring_next = ring_cnt + 1;
      ring_cnt = 8'(ring_next);
      if (ring_next >= set_ring) begin
        ringing = 1'b0;
      end
    end

    r.alarm_indicator = ringing;
    r.twelve_hour_mode = fmt12;
    r.clock_hours = 5'(hr_t * 10 + hr_u);
    r.clock_minutes = 6'(min_t * 10 + min_u);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PrintLimit) begin
      $display("[%0t] check failed: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (display_q.size() == 0) begin
        report_mismatch($sformatf("result %h with no tick pending", m_axis_tdata));
      end else begin
        want_result = display_q.pop_front();
        got_result = m_axis_tdata[25:0];
        check_field("digit_enable", got_result.digit_enable, want_result.digit_enable);
        check_field("segments", got_result.segments, want_result.segments);
        check_field("am_indicator", got_result.am_indicator, want_result.am_indicator);
        check_field("alarm_indicator", got_result.alarm_indicator,
                    want_result.alarm_indicator);
        check_field("twelve_hour_mode", got_result.twelve_hour_mode,
                    want_result.twelve_hour_mode);
        check_field("clock_hours", got_result.clock_hours, want_result.clock_hours);
        check_field("clock_minutes", got_result.clock_minutes, want_result.clock_minutes);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Long receiver hold-off, counted down here.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataWidth-1){1'b0}}, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
    display_q.push_back(predict_tick(lvl));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (display_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [CfgDataWidth-1:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_ALARM_HOUR:        set_alarm_hr = val[4:0];
      REG_ALARM_MINUTE:      set_alarm_min = val[5:0];
      REG_TICKS_PER_ADVANCE: set_tpa = val[15:0];
      REG_SETTLE_TICKS:      set_deb = val[7:0];
      REG_RING_PERIODS:      set_ring = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_alarm_ahead(input int minutes_ahead);
    int target;
    target = (minutes_now() + minutes_ahead) % 1440;
    write_reg(REG_ALARM_HOUR, 16'(target / 60));
    write_reg(REG_ALARM_MINUTE, 16'(target % 60));
  endtask

  // Button presses as runs of one level, mostly long enough to pass the debounce.
  task automatic drive_button_runs(input int n);
    int left;
    int run;
    logic lvl;
    left = n;
    lvl = 1'($urandom_range(1));
    while (left > 0) begin
      if (set_deb > 8'd12) begin
        run = $urandom_range(20, 1);
      end else if ($urandom_range(99) < 80) begin
        run = set_deb + $urandom_range(4, 1);
      end else begin
        run = $urandom_range(2, 1);
      end
      for (int i = 0; i < run && left > 0; i++) begin
        send_tick(lvl);
        left--;
      end
      lvl = ~lvl;
    end
  endtask

  task automatic apply_settings(input settings_mode_e mode);
    int pick;
    case (mode)
      SET_ALL_MAX: begin
        write_reg(REG_ALARM_HOUR, 16'd31);
        write_reg(REG_ALARM_MINUTE, 16'd63);
        write_reg(REG_TICKS_PER_ADVANCE, 16'hFFFF);
        write_reg(REG_SETTLE_TICKS, 16'd255);
        write_reg(REG_RING_PERIODS, 16'd255);
      end
      SET_ALL_MIN: begin
        write_reg(REG_ALARM_HOUR, 16'd0);
        write_reg(REG_ALARM_MINUTE, 16'd0);
        write_reg(REG_TICKS_PER_ADVANCE, 16'd0);
        write_reg(REG_SETTLE_TICKS, 16'd0);
        write_reg(REG_RING_PERIODS, 16'd0);
      end
      default: begin
        if ($urandom_range(99) < 70) begin
          set_alarm_ahead($urandom_range(8, 1));
        end else begin
          write_reg(REG_ALARM_HOUR, 16'($urandom_range(31)));
          write_reg(REG_ALARM_MINUTE, 16'($urandom_range(63)));
        end
        pick = $urandom_range(99);
        if (pick < 50) begin
          write_reg(REG_TICKS_PER_ADVANCE, 16'($urandom_range(1)));
        end else if (pick < 85) begin
          write_reg(REG_TICKS_PER_ADVANCE, 16'($urandom_range(6, 2)));
        end else if (pick < 95) begin
          write_reg(REG_TICKS_PER_ADVANCE, 16'($urandom_range(300, 7)));
        end else begin
          write_reg(REG_TICKS_PER_ADVANCE, 16'($urandom_range(65535)));
        end
        if ($urandom_range(99) < 85) begin
          write_reg(REG_SETTLE_TICKS, 16'($urandom_range(6)));
        end else begin
          write_reg(REG_SETTLE_TICKS, 16'($urandom_range(255)));
        end
        if ($urandom_range(99) < 85) begin
          write_reg(REG_RING_PERIODS, 16'($urandom_range(12)));
        end else begin
          write_reg(REG_RING_PERIODS, 16'($urandom_range(255)));
        end
      end
    endcase
  endtask

  // Reset settings: one full scan of the four digits, both button levels.
  task automatic test_reset_scan();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // With no debounce a press toggles the format on the same tick; no period advances every tick.
  task automatic test_zero_debounce();
    write_reg(REG_SETTLE_TICKS, 16'd0);
    write_reg(REG_TICKS_PER_ADVANCE, 16'd0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Lowering the debounce below the running count must not accept the held level.
  task automatic test_debounce_lowered();
    write_reg(REG_SETTLE_TICKS, 16'd10);
    write_reg(REG_TICKS_PER_ADVANCE, 16'd3);
    send_tick(1'b0);
    repeat (5) send_tick(1'b1);
    write_reg(REG_SETTLE_TICKS, 16'd2);
    repeat (2) send_tick(1'b1);
  endtask

  // Zero ring periods: the alarm stops at once and rings again within its minute.
  task automatic test_alarm_rering();
    write_reg(REG_TICKS_PER_ADVANCE, 16'd2);
    write_reg(REG_RING_PERIODS, 16'd0);
    set_alarm_ahead(1);
    repeat (5) send_tick(1'b0);
  endtask

  // Unreachable alarm, then a period lowered below the running prescale count.
  task automatic test_period_lowered();
    write_reg(REG_ALARM_HOUR, 16'd31);
    write_reg(REG_ALARM_MINUTE, 16'd63);
    write_reg(REG_TICKS_PER_ADVANCE, 16'hFFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    write_reg(REG_TICKS_PER_ADVANCE, 16'd1);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n,
                                     input settings_mode_e first_mode);
    int done;
    int chunk;
    set_idling(send_pct, recv_pct);
    apply_settings(first_mode);
    done = 0;
    while (done < n) begin
      chunk = $urandom_range(60, 20);
      drive_button_runs(chunk);
      done += chunk;
      apply_settings(SET_RANDOM);
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    set_idling(0, 0);
    write_reg(REG_TICKS_PER_ADVANCE, 16'd1);
    stall_left <= 60;
    drive_button_runs(40);
  endtask

  // Advance every tick for a few hours so the hour digits turn over in both formats.
  task automatic test_day_rollover();
    set_idling(0, 0);
    write_reg(REG_TICKS_PER_ADVANCE, 16'd0);
    write_reg(REG_SETTLE_TICKS, 16'd2);
    write_reg(REG_RING_PERIODS, 16'($urandom_range(20, 1)));
    set_alarm_ahead($urandom_range(150, 10));
    drive_button_runs(180);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_ALARM_HOUR;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left = 0;
    mismatches = 0;
    reset_predictor();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_idling(10, 77);
    test_reset_scan();
    test_zero_debounce();
    test_debounce_lowered();
    test_alarm_rering();
    test_period_lowered();
    test_random_traffic(10, 77, 160, SET_ALL_MAX);
    test_random_traffic(77, 10, 160, SET_ALL_MIN);
    test_backpressure();
    test_day_rollover();
    test_random_traffic(0, 0, 110, SET_RANDOM);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
